// File: design/tkpq_pkg.sv
package tkpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  primary;
    logic [7:0]  secondary;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cmd_t;

endpackage

// File: design/tkpq_if.sv
interface tkpq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  key_primary;
  logic [7:0]  key_secondary;
  logic [15:0] tag;

  modport source (output valid, op, key_primary, key_secondary, tag, input ready);
  modport sink   (input valid, op, key_primary, key_secondary, tag, output ready);
endinterface

interface tkpq_out_if;
  logic        valid;
  logic        ready;
  logic        head_valid;
  logic [7:0]  head_primary;
  logic [7:0]  head_secondary;
  logic [15:0] head_tag;
  logic [1:0]  status;
  logic [4:0]  occupancy;

  modport source (output valid, head_valid, head_primary, head_secondary, head_tag,
                  status, occupancy, input ready);
  modport sink   (input valid, head_valid, head_primary, head_secondary, head_tag,
                  status, occupancy, output ready);
endinterface

// File: design/tkpq_cell.sv
module tkpq_cell (
  input  logic            clk,
  input  tkpq_pkg::cmd_t  cmd,
  input  logic            active,
  input  logic            left_lt,
  input  tkpq_pkg::entry_t left_data,
  input  tkpq_pkg::entry_t right_data,
  output logic            lt,
  output tkpq_pkg::entry_t data
);
  import tkpq_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  assign lt   = active &&
                ({data_r.primary, data_r.secondary} <
                 {cmd.entry.primary, cmd.entry.secondary});
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (!lt) begin
        data_nxt = left_lt ? cmd.entry : left_data;
      end
    end else if (cmd.rem) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end
endmodule

// File: design/two_key_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH entries held in a row of cells, ordered by
// (primary, secondary) ascending; equal key pairs leave last-in-first-out. Each
// transaction on in_ch is an insert (op 0) or a remove of the head (op 1) and
// yields exactly one transaction on out_ch with status and occupancy. Every cell
// compares the new key at once and shifts by one toward its neighbor, so one
// transaction is taken per cycle; the single output register lets a new input in
// whenever the waiting result is taken in the same cycle. An insert into a full
// queue is dropped (status 1); a remove from an empty queue reports status 2.
module two_key_priority_queue (
  input  logic      clk,
  input  logic      rst_n,
  tkpq_in_if.sink   in_ch,
  tkpq_out_if.source out_ch
);
  import tkpq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovalid_r;
  logic             ohv_r;
  entry_t           ohead_r;
  logic [1:0]       ostat_r;
  logic [OCC_W-1:0] oocc_r;

  logic   accept, full, empty;
  cmd_t   cmd;
  logic   [QUEUE_DEPTH-1:0] lt;
  entry_t cell_data [QUEUE_DEPTH];
  logic   [1:0] stat;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  assign cmd.entry.primary   = in_ch.key_primary;
  assign cmd.entry.secondary = in_ch.key_secondary;
  assign cmd.entry.tag       = in_ch.tag;
  assign cmd.ins = accept && (in_ch.op == OP_INSERT) && !full;
  assign cmd.rem = accept && (in_ch.op == OP_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tkpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .active     (CNT_W'(i) < count_r),
        .left_lt    ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
        .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
        .right_data (cell_data[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
        .lt         (lt[i]),
        .data       (cell_data[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
    stat = ST_OK;
    if (in_ch.op == OP_INSERT && full) begin
      stat = ST_FULL;
    end else if (in_ch.op == OP_REMOVE && empty) begin
      stat = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ohv_r   <= cmd.rem;
      ohead_r <= cmd.rem ? cell_data[0] : '0;
      ostat_r <= stat;
      oocc_r  <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.head_valid     = ohv_r;
  assign out_ch.head_primary   = ohead_r.primary;
  assign out_ch.head_secondary = ohead_r.secondary;
  assign out_ch.head_tag       = ohead_r.tag;
  assign out_ch.status         = ostat_r;
  assign out_ch.occupancy      = oocc_r;
endmodule

// File: dv/pq_order_checker.sv
`timescale 1ns / 1ps

module pq_order_checker (
  input  logic clk,
  input  logic rst_n,
  tkpq_in_if   in_mon,
  tkpq_out_if  out_mon,
  output int   mismatches,
  output int   pending,
  output int   results_checked,
  output int   full_drops,
  output int   empty_removes,
  output int   peak_fill
);
  import tkpq_pkg::*;

  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic             head_valid;
    logic [7:0]       head_primary;
    logic [7:0]       head_secondary;
    logic [15:0]      head_tag;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
  } outcome_t;

  // shadow of the sorted queue, index 0 is the head
  entry_t   held [QUEUE_DEPTH];
  int       fill;
  outcome_t due_q [$];

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    if (mismatches < MAX_PRINTED)
      $display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_checked, field, got, want);
    mismatches++;
  endtask

  function automatic outcome_t apply_cmd(input logic op, input entry_t e);
    outcome_t r;
    int       pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (fill >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // ahead of every entry whose key pair is >= the new one
        pos = 0;
        while (pos < fill &&
               {held[pos].primary, held[pos].secondary} < {e.primary, e.secondary})
          pos++;
        for (int i = fill; i > pos; i--)
          held[i] = held[i-1];
        held[pos] = e;
        fill++;
        r.status = ST_OK;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.head_valid     = 1'b1;
      r.head_primary   = held[0].primary;
      r.head_secondary = held[0].secondary;
      r.head_tag       = held[0].tag;
      for (int i = 1; i < fill; i++)
        held[i-1] = held[i];
      fill--;
      r.status = ST_OK;
    end
    r.occupancy = fill[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    entry_t   e;
    if (!rst_n) begin
      fill            = 0;
      due_q.delete();
      mismatches      = 0;
      results_checked = 0;
      full_drops      = 0;
      empty_removes   = 0;
      peak_fill       = 0;
      pending        <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.head_valid, out_mon.head_primary, out_mon.head_secondary,
                out_mon.head_tag, out_mon.status, out_mon.occupancy};
        if (due_q.size() == 0) begin
          flag_mismatch("arrived with nothing outstanding", got, 0);
        end else begin
          want = due_q.pop_front();
          if (got.head_valid !== want.head_valid)
            flag_mismatch("head_valid", got.head_valid, want.head_valid);
          if (got.head_primary !== want.head_primary)
            flag_mismatch("head_primary", got.head_primary, want.head_primary);
          if (got.head_secondary !== want.head_secondary)
            flag_mismatch("head_secondary", got.head_secondary, want.head_secondary);
          if (got.head_tag !== want.head_tag)
            flag_mismatch("head_tag", got.head_tag, want.head_tag);
          if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
          if (got.occupancy !== want.occupancy)
            flag_mismatch("occupancy", got.occupancy, want.occupancy);
        end
        results_checked++;
      end
      if (in_mon.valid && in_mon.ready) begin
        e    = '{in_mon.key_primary, in_mon.key_secondary, in_mon.tag};
        want = apply_cmd(in_mon.op, e);
        if (want.status == ST_FULL)  full_drops++;
        if (want.status == ST_EMPTY) empty_removes++;
        if (fill > peak_fill) peak_fill = fill;
        due_q.push_back(want);
      end
      pending <= due_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tkpq_pkg::*;

  localparam int TOTAL_ITEMS = 900;
  localparam int LONG_HOLD   = 80;
  localparam int HOLD_AFTER  = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 10;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;
  localparam int MODE_TIES  = 3;

  logic clk;
  logic rst_n;

  tkpq_in_if  in_ch ();
  tkpq_out_if out_ch ();

  int  mismatches, pending, results_checked, full_drops, empty_removes, peak_fill;
  int  items_sent, inserts_sent, removes_sent, idle_cycles;
  bit  tx_calm;

  two_key_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pq_order_checker order_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .full_drops      (full_drops),
    .empty_removes   (empty_removes),
    .peak_fill       (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic op, input entry_t e);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.key_primary   <= e.primary;
    in_ch.key_secondary <= e.secondary;
    in_ch.tag           <= e.tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (op == OP_INSERT) inserts_sent++;
    else removes_sent++;
    @(negedge clk);
  endtask

  function automatic entry_t draw_entry(input bit narrow);
    entry_t e;
    int     pick;
    if (narrow) begin
      pick = $urandom_range(0, 2);
      e.primary   = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(1, 2));
      e.secondary = 8'($urandom_range(0, 3));
    end else begin
      e.primary   = 8'($urandom);
      e.secondary = 8'($urandom);
    end
    e.tag = 16'($urandom);
    return e;
  endfunction

  initial begin : stimulus
    logic [31:0] seed_words [QUEUE_DEPTH];
    int          burst, mode, ins_pct;
    logic        op;
    seed_words = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                   32'h8001_A5A5, 32'h8000_5A5A, 32'h80FF_C3C3, 32'hFF00_3C3C,
                   32'h7FFF_0101, 32'h0180_FEFE, 32'hFFFF_0000, 32'h55AA_1234,
                   32'hAA55_4321, 32'h8001_0F0F, 32'h4040_F0F0, 32'h1020_8001};
    items_sent    = 0;
    inserts_sent  = 0;
    removes_sent  = 0;
    tx_calm       = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_INSERT;
    in_ch.key_primary   = '0;
    in_ch.key_secondary = '0;
    in_ch.tag           = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty remove, fill with extremes and ties, overflow, partial drain
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    foreach (seed_words[i])
      send_item(OP_INSERT, seed_words[i]);
    send_item(OP_INSERT, 32'h0000_DEAD);
    repeat (7) send_item(OP_REMOVE, 32'h0);

    while (items_sent < TOTAL_ITEMS) begin
      burst   = $urandom_range(10, 60);
      mode    = $urandom_range(MODE_FILL, MODE_TIES);
      tx_calm = ($urandom_range(0, 3) == 0);
      case (mode)
        MODE_FILL:  ins_pct = 85;
        MODE_DRAIN: ins_pct = 15;
        default:    ins_pct = 50;
      endcase
      repeat (burst) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_item(op, draw_entry(mode == MODE_TIES || $urandom_range(0, 4) == 0));
      end
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Ran %0d transactions (%0d inserts, %0d removes), checked %0d results.",
             items_sent, inserts_sent, removes_sent, results_checked);
    $display("Dropped on full: %0d, removes on empty: %0d, peak fill %0d of %0d.",
             full_drops, empty_removes, peak_fill, QUEUE_DEPTH);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_taker
    int gap;
    int taken;
    bit calm;
    bit long_hold_done;
    out_ch.ready   = 1'b0;
    taken          = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 6);
      // one long back-pressure stretch while the sender keeps offering
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
